// File: rtl/vmv_pkg.sv
package vmv_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_COUNT   = 2'd1,
    PH_OFFSETS = 2'd2,
    PH_STRINGS = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VERSION = 3'd1,
    ST_SHORT_COUNT = 3'd2,
    ST_SHORT_OFFS  = 3'd3,
    ST_DECREASING  = 3'd4,
    ST_OVERRUN     = 3'd5
  } status_t;

  localparam logic [3:0] VERSION_MASK = 4'hF;
  localparam logic [3:0] VERSION_ONE  = 4'h1;
  localparam logic [1:0] WIDTH_MASK   = 2'h3;
  localparam logic [2:0] MAX_WIDTH    = 3'd4;

  typedef struct packed {
    logic [7:0] blob_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        sorted_dictionary;
    logic [2:0]  offset_bytes;
    logic [31:0] dictionary_entries;
    logic [31:0] string_bytes;
  } out_t;

  // result handed from the parser to the output buffer
  typedef struct packed {
    logic fire;
    out_t word;
  } res_t;

endpackage

// File: rtl/variant_metadata_validator_unit.sv
// Variant metadata header validator.
// in_*  : one blob byte per word, final_byte set on the last byte of a blob.
// out_* : one result word per blob (status, header flags, decoded count and
//         string length), nothing for the other bytes.
// Throughput: one byte per cycle while in_ready is high. Each byte is folded into
// the parser state in the cycle it is accepted; the result of a final byte is registered
// and shows on out_valid the next cycle if the output register is free or draining.
// The result side holds two words: an output register and a skid register.
// A stalled receiver therefore does not stop the byte stream until two
// results are waiting; in_ready then drops until the output register drains.
// The string length counter saturates at 2^COUNT_WIDTH-1.
// After a final byte the parser returns to its header state, so the next
// byte starts a new blob.
// Reset (rst_n low, synchronous) empties both result registers and puts the
// parser in its header state.
module variant_metadata_validator_unit #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  vmv_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output vmv_pkg::out_t out_data
);

  vmv_pkg::res_t res;
  logic          take;
  logic          out_valid_r, out_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  vmv_pkg::out_t out_data_r, out_data_nxt;
  vmv_pkg::out_t skid_r, skid_nxt;

  assign in_ready  = !skid_valid_r;
  assign take      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  vmv_parse #(.COUNT_WIDTH(COUNT_WIDTH)) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_word (in_data),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res.fire;
        out_data_nxt  = res.word;
      end
    end else if (res.fire) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    skid_r     <= skid_nxt;
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with empty output register");

  a_no_result_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res.fire |-> !skid_valid_r)
    else $error("result produced with both result registers full");

  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.offset_bytes != 3'd0 &&
                     out_data_r.offset_bytes <= vmv_pkg::MAX_WIDTH))
    else $error("offset width out of range");

  a_short_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == vmv_pkg::ST_SHORT_COUNT)
      |-> (out_data_r.dictionary_entries == 32'd0 && out_data_r.string_bytes == 32'd0))
    else $error("short count result carries decoded fields");

endmodule

// File: rtl/vmv_parse.sv
module vmv_parse #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  vmv_pkg::in_t  in_word,
  output vmv_pkg::res_t res
);

  vmv_pkg::phase_t          phase_r, phase_nxt;
  logic                     version_bad_r, version_bad_nxt;
  logic                     sorted_r, sorted_nxt;
  logic [2:0]               width_r, width_nxt;
  logic [1:0]               pos_r, pos_nxt;
  logic [31:0]              dict_r, dict_nxt;
  logic [31:0]              asm_r, asm_nxt;
  logic [32:0]              left_r, left_nxt;
  logic [31:0]              prev_r, prev_nxt;
  logic                     first_r, first_nxt;
  logic                     broken_r, broken_nxt;
  logic [COUNT_WIDTH-1:0]   str_r, str_nxt;

  logic [31:0] asm_full;
  logic        word_done;
  logic [7:0]  b;

  assign b         = in_word.blob_byte;
  assign asm_full  = asm_r | (32'(b) << {pos_r, 3'b000});
  assign word_done = ({1'b0, pos_r} + 3'd1) >= width_r;

  always_comb begin
    phase_nxt       = phase_r;
    version_bad_nxt = version_bad_r;
    sorted_nxt      = sorted_r;
    width_nxt       = width_r;
    pos_nxt         = pos_r;
    dict_nxt        = dict_r;
    asm_nxt         = asm_r;
    left_nxt        = left_r;
    prev_nxt        = prev_r;
    first_nxt       = first_r;
    broken_nxt      = broken_r;
    str_nxt         = str_r;
    unique case (phase_r)
      vmv_pkg::PH_HEADER: begin
        version_bad_nxt = (b[3:0] & vmv_pkg::VERSION_MASK) != vmv_pkg::VERSION_ONE;
        sorted_nxt      = b[4];
        width_nxt       = {1'b0, b[7:6] & vmv_pkg::WIDTH_MASK} + 3'd1;
        pos_nxt         = 2'd0;
        asm_nxt         = 32'd0;
        phase_nxt       = vmv_pkg::PH_COUNT;
      end
      vmv_pkg::PH_COUNT: begin
        if (word_done) begin
          pos_nxt   = 2'd0;
          dict_nxt  = asm_full;
          left_nxt  = {1'b0, asm_full} + 33'd1;
          asm_nxt   = 32'd0;
          phase_nxt = vmv_pkg::PH_OFFSETS;
        end else begin
          pos_nxt = pos_r + 2'd1;
          asm_nxt = asm_full;
        end
      end
      vmv_pkg::PH_OFFSETS: begin
        if (word_done) begin
          pos_nxt = 2'd0;
          if (!first_r && (asm_full < prev_r)) broken_nxt = 1'b1;
          first_nxt = 1'b0;
          prev_nxt  = asm_full;
          asm_nxt   = 32'd0;
          // left is never zero while in this phase
          left_nxt  = left_r - 33'd1;
          if (left_r == 33'd1) phase_nxt = vmv_pkg::PH_STRINGS;
        end else begin
          pos_nxt = pos_r + 2'd1;
          asm_nxt = asm_full;
        end
      end
      vmv_pkg::PH_STRINGS: begin
        if (str_r != {COUNT_WIDTH{1'b1}}) str_nxt = str_r + COUNT_WIDTH'(1);
      end
      default: phase_nxt = vmv_pkg::PH_HEADER;
    endcase
  end

  // result from the state as it stands after this byte
  always_comb begin
    vmv_pkg::status_t st;
    if (version_bad_nxt) st = vmv_pkg::ST_BAD_VERSION;
    else if (phase_nxt == vmv_pkg::PH_HEADER || phase_nxt == vmv_pkg::PH_COUNT)
      st = vmv_pkg::ST_SHORT_COUNT;
    else if (phase_nxt == vmv_pkg::PH_OFFSETS) st = vmv_pkg::ST_SHORT_OFFS;
    else if (broken_nxt) st = vmv_pkg::ST_DECREASING;
    else if (prev_nxt > 32'(str_nxt)) st = vmv_pkg::ST_OVERRUN;
    else st = vmv_pkg::ST_OK;
    res.fire                   = take && in_word.final_byte;
    res.word.status            = st;
    res.word.sorted_dictionary = sorted_nxt;
    res.word.offset_bytes      = width_nxt;
    res.word.dictionary_entries =
      (phase_nxt == vmv_pkg::PH_OFFSETS || phase_nxt == vmv_pkg::PH_STRINGS) ?
      dict_nxt : 32'd0;
    res.word.string_bytes = (phase_nxt == vmv_pkg::PH_STRINGS) ? 32'(str_nxt) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && in_word.final_byte)) begin
      phase_r       <= vmv_pkg::PH_HEADER;
      version_bad_r <= 1'b0;
      sorted_r      <= 1'b0;
      width_r       <= 3'd1;
      pos_r         <= 2'd0;
      dict_r        <= 32'd0;
      asm_r         <= 32'd0;
      left_r        <= 33'd0;
      prev_r        <= 32'd0;
      first_r       <= 1'b1;
      broken_r      <= 1'b0;
      str_r         <= '0;
    end else if (take) begin
      phase_r       <= phase_nxt;
      version_bad_r <= version_bad_nxt;
      sorted_r      <= sorted_nxt;
      width_r       <= width_nxt;
      pos_r         <= pos_nxt;
      dict_r        <= dict_nxt;
      asm_r         <= asm_nxt;
      left_r        <= left_nxt;
      prev_r        <= prev_nxt;
      first_r       <= first_nxt;
      broken_r      <= broken_nxt;
      str_r         <= str_nxt;
    end
  end

endmodule

// File: dv/variant_metadata_validator_unit_tb.sv
`timescale 1ns / 1ps

module variant_metadata_validator_unit_tb;

  localparam int BYTE_TARGET = 1850;
  localparam int SETTLE_CYCLES = 10;

  // Tracks the parser state of the blob in flight and holds the reports still owed.
  class header_scoreboard;
    vmv_pkg::phase_t ph;
    bit          bad_ver;
    bit          sorted;
    logic [2:0]  width;
    logic [1:0]  pos;
    logic [31:0] dict_count;
    logic [31:0] word;
    logic [32:0] offs_left;
    logic [31:0] prev_off;
    bit          first_off;
    bit          broken;
    logic [31:0] str_count;

    vmv_pkg::out_t awaited_reports[$];
    int   errors;
    int   bytes_seen;
    int   status_hits[8];

    function new();
      errors = 0;
      bytes_seen = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      ph = vmv_pkg::PH_HEADER;
      bad_ver = 0;
      sorted = 0;
      width = 3'd1;
      pos = 2'd0;
      dict_count = '0;
      word = '0;
      offs_left = '0;
      prev_off = '0;
      first_off = 1;
      broken = 0;
      str_count = '0;
    endfunction

    // little-endian assembly; true once width bytes are in
    function bit gather(logic [7:0] b);
      word = word | (32'(b) << (8 * pos));
      if (({1'b0, pos} + 3'd1) >= width) begin
        pos = 2'd0;
        return 1;
      end
      pos = pos + 2'd1;
      return 0;
    endfunction

    function void fold_byte(vmv_pkg::in_t d);
      vmv_pkg::out_t r;
      bytes_seen++;
      case (ph)
        vmv_pkg::PH_HEADER: begin
          bad_ver = (d.blob_byte[3:0] & vmv_pkg::VERSION_MASK) != vmv_pkg::VERSION_ONE;
          sorted = d.blob_byte[4];
          width = {1'b0, d.blob_byte[7:6]} + 3'd1;
          pos = 2'd0;
          word = '0;
          ph = vmv_pkg::PH_COUNT;
        end
        vmv_pkg::PH_COUNT: begin
          if (gather(d.blob_byte)) begin
            dict_count = word;
            offs_left = {1'b0, word} + 33'd1;
            word = '0;
            ph = vmv_pkg::PH_OFFSETS;
          end
        end
        vmv_pkg::PH_OFFSETS: begin
          if (gather(d.blob_byte)) begin
            if (!first_off && word < prev_off) broken = 1;
            first_off = 0;
            prev_off = word;
            word = '0;
            if (offs_left != 0) offs_left = offs_left - 33'd1;
            if (offs_left == 0) ph = vmv_pkg::PH_STRINGS;
          end
        end
        default: begin
          // saturating; the top of the range is out of reach in a practical run
          if (str_count != '1) str_count = str_count + 32'd1;
        end
      endcase
      if (!d.final_byte) return;

      if (bad_ver) r.status = vmv_pkg::ST_BAD_VERSION;
      else if (ph == vmv_pkg::PH_HEADER || ph == vmv_pkg::PH_COUNT)
        r.status = vmv_pkg::ST_SHORT_COUNT;
      else if (ph == vmv_pkg::PH_OFFSETS) r.status = vmv_pkg::ST_SHORT_OFFS;
      else if (broken) r.status = vmv_pkg::ST_DECREASING;
      else if (prev_off > str_count) r.status = vmv_pkg::ST_OVERRUN;
      else r.status = vmv_pkg::ST_OK;
      r.sorted_dictionary = sorted;
      r.offset_bytes = width;
      r.dictionary_entries =
        (ph == vmv_pkg::PH_OFFSETS || ph == vmv_pkg::PH_STRINGS) ? dict_count : '0;
      r.string_bytes = (ph == vmv_pkg::PH_STRINGS) ? str_count : '0;
      awaited_reports.push_back(r);
      status_hits[r.status]++;
      clear_parser();
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void compare_report(vmv_pkg::out_t got);
      vmv_pkg::out_t want;
      if (awaited_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, got %h", $time, got);
        return;
      end
      want = awaited_reports.pop_front();
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("sorted_dictionary", 32'(want.sorted_dictionary),
                  32'(got.sorted_dictionary));
      check_field("offset_bytes", 32'(want.offset_bytes), 32'(got.offset_bytes));
      check_field("dictionary_entries", want.dictionary_entries, got.dictionary_entries);
      check_field("string_bytes", want.string_bytes, got.string_bytes);
    endfunction

    function int backlog();
      return awaited_reports.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  vmv_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  vmv_pkg::out_t out_data;

  header_scoreboard sb;
  logic [7:0] blob_q[$];
  bit no_idle;
  int blobs_sent;

  variant_metadata_validator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task send_byte(input vmv_pkg::in_t d);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    sb.fold_byte(d);
  endtask

  task send_blob();
    vmv_pkg::in_t d;
    for (int i = 0; i < blob_q.size(); i++) begin
      d.blob_byte  = blob_q[i];
      d.final_byte = (i == blob_q.size() - 1);
      send_byte(d);
    end
    blobs_sent++;
  endtask

  // hold the sender off until every owed report has come out
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.backlog() != 0) @(posedge clk);
  endtask

  // mostly well-formed blobs with random content; some noise, bad versions,
  // truncation, broken ordering and overruns
  task make_blob();
    int kind, w, r, slen, n_off, cut;
    logic [31:0] mask, cnt, val, prev;
    logic [7:0] hdr;
    logic [31:0] offs[$];
    blob_q.delete();
    offs.delete();
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      repeat ($urandom_range(1, 12)) blob_q.push_back(8'($urandom));
      return;
    end
    w = $urandom_range(1, 4);
    mask = (w == 4) ? 32'hFFFF_FFFF : ((32'h1 << (8 * w)) - 32'h1);
    hdr = 8'($urandom);
    hdr[7:6] = 2'(w - 1);
    hdr[3:0] = (kind < 14) ? 4'($urandom_range(0, 15)) : vmv_pkg::VERSION_ONE;
    blob_q.push_back(hdr);

    r = $urandom_range(0, 9);
    if (r < 6) cnt = $urandom_range(0, 4);
    else if (r < 9) cnt = 32'($urandom_range(0, 24)) & mask;
    else cnt = $urandom & mask;
    for (int k = 0; k < w; k++) blob_q.push_back(cnt[8*k +: 8]);

    slen = ($urandom_range(0, 99) < 5) ? $urandom_range(40, 300) : $urandom_range(0, 10);
    n_off = (cnt > 40) ? $urandom_range(0, 5) : int'(cnt) + 1;
    prev = '0;
    for (int i = 0; i < n_off; i++) begin
      if (kind < 24) val = $urandom & mask;
      else if ($urandom_range(0, 2) == 0) val = prev + $urandom_range(0, slen - int'(prev));
      else val = prev;
      offs.push_back(val);
      prev = val;
    end
    if (n_off > 0 && kind >= 24 && kind < 32) offs[n_off-1] += $urandom_range(1, 3);
    if (n_off > 1 && kind >= 32 && kind < 40) begin
      r = $urandom_range(1, n_off - 1);
      offs[r-1] = offs[r] + 32'd1;
    end
    foreach (offs[i])
      for (int k = 0; k < w; k++) blob_q.push_back(offs[i][8*k +: 8]);
    if (cnt <= 40)
      repeat (slen) blob_q.push_back(8'($urandom));

    if (kind >= 40 && kind < 52) begin
      cut = $urandom_range(1, blob_q.size());
      while (blob_q.size() > cut) void'(blob_q.pop_back());
    end
  endtask

  // result side: long open stretches, short stalls, the odd long one
  initial begin : ready_gen
    int left;
    bit lvl;
    left = 0;
    lvl = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        left = $urandom_range(0, 99);
        if (left < 45) begin
          lvl = 1'b1;
          left = $urandom_range(1, 60);
        end else if (left < 90) begin
          lvl = 1'b0;
          left = $urandom_range(1, 3);
        end else begin
          lvl = 1'b0;
          left = $urandom_range(10, 40);
        end
      end
      left--;
      out_ready <= lvl;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.compare_report(out_data);
  end

  initial begin : watchdog
    #10_000_000;
    $display("variant_metadata_validator_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    blobs_sent = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // header only, bad version with sorted flag, empty dictionary, overrun,
    // decreasing offsets, offsets cut short, widest count with no offsets following
    blob_q = '{8'h01};
    send_blob();
    blob_q = '{8'hF2};
    send_blob();
    blob_q = '{8'h01, 8'h00, 8'h00};
    send_blob();
    blob_q = '{8'h11, 8'h01, 8'h00, 8'h03, 8'h61, 8'h62};
    send_blob();
    blob_q = '{8'h01, 8'h02, 8'h02, 8'h01, 8'h02, 8'h78, 8'h79};
    send_blob();
    blob_q = '{8'h41, 8'h01, 8'h00, 8'h01};
    send_blob();
    blob_q = '{8'hC1, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_blob();
    drain();

    while (sb.bytes_seen < BYTE_TARGET) begin
      make_blob();
      no_idle = ($urandom_range(0, 4) == 0);
      send_blob();
      if (blobs_sent % 97 == 50) drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d bytes in %0d blobs; reports ok %0d, bad version %0d,",
             sb.bytes_seen, blobs_sent, sb.status_hits[vmv_pkg::ST_OK],
             sb.status_hits[vmv_pkg::ST_BAD_VERSION]);
    $display("short count %0d, short offsets %0d, decreasing %0d, overrun %0d; %0d mismatches",
             sb.status_hits[vmv_pkg::ST_SHORT_COUNT], sb.status_hits[vmv_pkg::ST_SHORT_OFFS],
             sb.status_hits[vmv_pkg::ST_DECREASING], sb.status_hits[vmv_pkg::ST_OVERRUN],
             sb.errors);
    if (sb.errors == 0) begin
      $display("variant_metadata_validator_unit regression: pass");
    end else begin
      $display("variant_metadata_validator_unit regression: fail");
    end
    $finish;
  end

endmodule
